FILE: src/tct_pkg.sv
package tct_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   // TCP flag bits
   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_ACK = 8'h10;
   localparam logic [7:0] PURE_SYN = 8'h02;

   // Connection states
   localparam logic [2:0] CONN_SYN_SENT = 3'd0;
   localparam logic [2:0] CONN_SYNACK   = 3'd1;
   localparam logic [2:0] CONN_ESTAB    = 3'd2;
   localparam logic [2:0] CONN_CLOSED   = 3'd3;
   localparam logic [2:0] CONN_DROPPED  = 3'd4;
   localparam logic [2:0] CONN_FAILED   = 3'd5;

   // Result status codes
   localparam logic [2:0] RES_CREATED    = 3'd0;
   localparam logic [2:0] RES_UPDATED    = 3'd1;
   localparam logic [2:0] RES_UNEXPECTED = 3'd2;
   localparam logic [2:0] RES_UNKNOWN    = 3'd3;
   localparam logic [2:0] RES_FULL       = 3'd4;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  tcp_flags;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] entry_index;
      logic       reverse_match;
      logic [2:0] conn_state;
      logic [7:0] syn_retry_count;
   } rsp_type;

   // Per-slot handshake status kept in the table.
   typedef struct packed {
      logic [2:0] conn_state;
      logic [7:0] retries;
   } entry_stat_type;

   typedef logic [95:0] conn_key_type;

endpackage

FILE: src/tcp_connection_tracker.sv
// Channel   Direction  Ports                                  Content
// req       in         req_valid, req_stall, req_payload      one packet header
// rsp       out        rsp_valid, rsp_stall, rsp_payload      one tracking result
//
// A packet passes from its transfer through fetch, a scan of at most the fill count of slots
// (ending early on a forward match) and decide; an empty table skips fetch and scan.
// The table memory has one read port and one slot is compared per cycle.
// Reset clears fill count and flags but no slot; filled in order, slots need no clearing pass.
// A new packet is taken while a finished result still waits; the update step waits on rsp_stall.
module tcp_connection_tracker import tct_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = IW + 1;
   localparam int SW = (IW > 6) ? IW : 6;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FETCH  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   // Table memories
   conn_key_type   key_mem_ff  [TABLE_ENTRIES];
   entry_stat_type stat_mem_ff [TABLE_ENTRIES];
   conn_key_type   key_rd_ff;
   entry_stat_type stat_rd_ff;

   logic [1:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  addr_ff, addr_in;
   logic [IW-1:0]  cmp_idx_ff;
   req_type        req_ff, req_in;
   logic           fwd_hit_ff, fwd_hit_in;
   logic [IW-1:0]  fwd_slot_ff, fwd_slot_in;
   entry_stat_type fwd_stat_ff, fwd_stat_in;
   logic           rev_hit_ff, rev_hit_in;
   logic [IW-1:0]  rev_slot_ff, rev_slot_in;
   entry_stat_type rev_stat_ff, rev_stat_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   conn_key_type   fwd_key, rev_key;
   logic           fwd_eq, rev_eq, last_slot, can_go;
   logic           sel_hit, sel_rev;
   logic [IW-1:0]  sel_slot;
   entry_stat_type sel_stat, upd_stat;
   logic [2:0]     upd_status;
   logic [SW-1:0]  slot_ext;
   logic           key_we, stat_we;
   logic [IW-1:0]  wr_addr;
   entry_stat_type wr_stat;
   logic           is_syn, is_ack, is_rst, is_fin;

   assign fwd_key = {req_ff.src_addr, req_ff.dst_addr, req_ff.src_port, req_ff.dst_port};
   assign rev_key = {req_ff.dst_addr, req_ff.src_addr, req_ff.dst_port, req_ff.src_port};

   // Both directions are checked against the slot read last cycle.
   assign fwd_eq    = (key_rd_ff == fwd_key);
   assign rev_eq    = (key_rd_ff == rev_key);
   assign last_slot = ({1'b0, cmp_idx_ff} == (count_ff - CW'(1)));
   assign can_go    = !rsp_valid_ff || !rsp_stall;

   assign is_syn = |(req_ff.tcp_flags & FLAG_SYN);
   assign is_ack = |(req_ff.tcp_flags & FLAG_ACK);
   assign is_rst = |(req_ff.tcp_flags & FLAG_RST);
   assign is_fin = |(req_ff.tcp_flags & FLAG_FIN);

   // A forward match anywhere beats any reversed match.
   assign sel_hit  = fwd_hit_ff || rev_hit_ff;
   assign sel_rev  = !fwd_hit_ff && rev_hit_ff;
   assign sel_slot = fwd_hit_ff ? fwd_slot_ff : rev_slot_ff;
   assign sel_stat = fwd_hit_ff ? fwd_stat_ff : rev_stat_ff;
   assign slot_ext = SW'(sel_slot);

   always_comb begin
      upd_stat   = sel_stat;
      upd_status = RES_UPDATED;
      unique case (sel_stat.conn_state)
         CONN_SYN_SENT: begin
            if (is_syn && is_ack) begin
               upd_stat.conn_state = CONN_SYNACK;
            end else if (is_syn) begin
               if (sel_stat.retries != 8'hFF) begin
                  upd_stat.retries = sel_stat.retries + 8'd1;
               end
            end else if (is_rst) begin
               upd_stat.conn_state = CONN_FAILED;
            end else begin
               upd_status = RES_UNEXPECTED;
            end
         end
         CONN_SYNACK: begin
            if (is_rst) begin
               upd_stat.conn_state = CONN_FAILED;
            end else if (is_ack) begin
               upd_stat.conn_state = CONN_ESTAB;
            end else begin
               upd_status = RES_UNEXPECTED;
            end
         end
         CONN_ESTAB: begin
            if (is_rst) begin
               upd_stat.conn_state = CONN_DROPPED;
            end else if (is_fin) begin
               upd_stat.conn_state = CONN_CLOSED;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      req_in       = req_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_slot_in  = fwd_slot_ff;
      fwd_stat_in  = fwd_stat_ff;
      rev_hit_in   = rev_hit_ff;
      rev_slot_in  = rev_slot_ff;
      rev_stat_in  = rev_stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      key_we       = 1'b0;
      stat_we      = 1'b0;
      wr_addr      = sel_slot;
      wr_stat      = upd_stat;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_payload;
               addr_in    = '0;
               fwd_hit_in = 1'b0;
               rev_hit_in = 1'b0;
               state_in   = (count_ff == '0) ? ST_DECIDE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            addr_in  = addr_ff + IW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            addr_in = addr_ff + IW'(1);
            if (fwd_eq) begin
               fwd_hit_in  = 1'b1;
               fwd_slot_in = cmp_idx_ff;
               fwd_stat_in = stat_rd_ff;
               state_in    = ST_DECIDE;
            end else begin
               if (rev_eq && !rev_hit_ff) begin
                  rev_hit_in  = 1'b1;
                  rev_slot_in = cmp_idx_ff;
                  rev_stat_in = stat_rd_ff;
               end
               if (last_slot) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (can_go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_in       = '0;
               if (sel_hit) begin
                  stat_we                = 1'b1;
                  rsp_in.status          = upd_status;
                  rsp_in.entry_index     = slot_ext[5:0];
                  rsp_in.reverse_match   = sel_rev;
                  rsp_in.conn_state      = upd_stat.conn_state;
                  rsp_in.syn_retry_count = upd_stat.retries;
               end else if (req_ff.tcp_flags != PURE_SYN) begin
                  rsp_in.status = RES_UNKNOWN;
               end else if (count_ff == CW'(TABLE_ENTRIES)) begin
                  rsp_in.status = RES_FULL;
               end else begin
                  // New slots always go at the fill count, the lowest free slot.
                  key_we             = 1'b1;
                  stat_we            = 1'b1;
                  wr_addr            = count_ff[IW-1:0];
                  wr_stat            = '{conn_state: CONN_SYN_SENT, retries: 8'd0};
                  count_in           = count_ff + CW'(1);
                  rsp_in.status      = RES_CREATED;
                  rsp_in.entry_index = 6'(SW'(count_ff[IW-1:0]));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[wr_addr] <= fwd_key;
      end
      if (stat_we) begin
         stat_mem_ff[wr_addr] <= wr_stat;
      end
      key_rd_ff  <= key_mem_ff[addr_ff];
      stat_rd_ff <= stat_mem_ff[addr_ff];
      cmp_idx_ff <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fwd_hit_ff   <= 1'b0;
         rev_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fwd_hit_ff   <= fwd_hit_in;
         rev_hit_ff   <= rev_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      req_ff      <= req_in;
      fwd_slot_ff <= fwd_slot_in;
      fwd_stat_ff <= fwd_stat_in;
      rev_slot_ff <= rev_slot_in;
      rev_stat_ff <= rev_stat_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count exceeds table size");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, cmp_idx_ff} < count_ff))
      else $error("scan compared a slot beyond the fill count");

   a_count_on_create: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
      |-> (rsp_valid_ff && (rsp_ff.status == RES_CREATED)))
      else $error("fill count moved without a created result");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_DECIDE))
      else $error("result raised outside the decide step");

endmodule
